// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/wfg_pkg.sv -----
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared constants, command codes and control/status types.
// ----------------------------------------------------------------------------
package wfg_pkg;

    localparam int NUM_PROCS = 16;
    localparam int NUM_RES   = 16;
    localparam int PROC_W    = $clog2(NUM_PROCS);
    localparam int RES_W     = $clog2(NUM_RES);
    localparam int CUR_W     = PROC_W + RES_W + 1;
    localparam int DEPTH_W   = $clog2(NUM_PROCS + 1);
    localparam int FRAME_W   = PROC_W + CUR_W;
    localparam int CMD_W     = 3;
    localparam int MASK_W    = 16;

    localparam logic [CMD_W-1:0] CMD_ADD_PROC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_RES  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REQUEST  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_PROC = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_RES  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DETECT   = 3'd6;

    typedef struct packed {
        logic upd;
        logic det_init;
        logic sel_take;
        logic sel_skip;
        logic scan_adv;
        logic push;
        logic pop;
        logic load_parent;
        logic finish_found;
        logic finish_none;
    } t_dp_cmd;

    typedef struct packed {
        logic start_end;
        logic start_ok;
        logic frame_end;
        logic edge_hit;
        logic hit_on_stack;
        logic hit_visited;
        logic depth_one;
    } t_dp_status;

endpackage

// ----- rtl/wfg_ctrl.sv -----
// ----------------------------------------------------------------------------
// wfg_ctrl
// Sequencer for update commands and the depth-first cycle search.
// ----------------------------------------------------------------------------
module wfg_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wfg_pkg::CMD_W-1:0] i_cmd,
    input  wfg_pkg::t_dp_status       i_status,
    output wfg_pkg::t_dp_cmd          o_cmd,
    output logic                      o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_SCAN,
        S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == wfg_pkg::CMD_DETECT) begin
                        o_cmd.det_init = 1'b1;
                        n_state        = S_SEL;
                    end else begin
                        o_cmd.upd = 1'b1;
                    end
                end
            end
            S_SEL: begin
                if (i_status.start_end) begin
                    o_cmd.finish_none = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_status.start_ok) begin
                    o_cmd.sel_take = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    o_cmd.sel_skip = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_status.frame_end) begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_status.depth_one ? S_SEL : S_LOAD;
                end else if (i_status.edge_hit && i_status.hit_on_stack) begin
                    o_cmd.finish_found = 1'b1;
                    n_state            = S_IDLE;
                end else if (i_status.edge_hit && !i_status.hit_visited) begin
                    o_cmd.push = 1'b1;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            S_LOAD: begin
                o_cmd.load_parent = 1'b1;
                n_state           = S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- rtl/wfg_dp.sv -----
// ----------------------------------------------------------------------------
// wfg_dp
// Graph state, search registers, frame stack memory and result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wfg_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wfg_pkg::t_dp_cmd            i_cmd_ctl,
    input  logic [wfg_pkg::CMD_W-1:0]   i_cmd,
    input  logic [wfg_pkg::PROC_W-1:0]  i_proc_index,
    input  logic [wfg_pkg::RES_W-1:0]   i_res_index,
    output wfg_pkg::t_dp_status         o_status,
    output logic                        o_valid,
    output logic                        o_applied,
    output logic                        o_deadlock_found,
    output logic [wfg_pkg::MASK_W-1:0]  o_cycle_mask
);

    logic [wfg_pkg::NUM_PROCS-1:0] r_proc_present;
    logic [wfg_pkg::NUM_RES-1:0]   r_res_present;
    logic [wfg_pkg::NUM_RES-1:0]   r_req  [wfg_pkg::NUM_PROCS];
    logic [wfg_pkg::NUM_RES-1:0]   r_hold [wfg_pkg::NUM_PROCS];
    logic [wfg_pkg::NUM_PROCS-1:0] r_visited;
    logic [wfg_pkg::NUM_PROCS-1:0] r_on_stack;
    logic [wfg_pkg::DEPTH_W-1:0]   r_depth;
    logic [wfg_pkg::DEPTH_W-1:0]   r_start;
    logic [wfg_pkg::PROC_W-1:0]    r_cur_proc;
    logic [wfg_pkg::CUR_W-1:0]     r_cursor;
    logic [wfg_pkg::FRAME_W-1:0]   r_frames [wfg_pkg::NUM_PROCS];
    logic [wfg_pkg::FRAME_W-1:0]   r_rd_frame;
    logic                          r_out_valid;
    logic                          r_applied;
    logic                          r_found;
    logic [wfg_pkg::MASK_W-1:0]    r_mask;

    logic [wfg_pkg::PROC_W-1:0]    w_start_idx;
    logic [wfg_pkg::PROC_W-1:0]    w_h;
    logic [wfg_pkg::RES_W-1:0]     w_r;
    logic [wfg_pkg::CUR_W-1:0]     w_cursor_inc;
    logic [wfg_pkg::PROC_W-1:0]    w_wr_addr;
    logic [wfg_pkg::PROC_W-1:0]    w_rd_addr;
    logic                          w_applied;

    assign w_start_idx  = r_start[wfg_pkg::PROC_W-1:0];
    assign w_h          = r_cursor[wfg_pkg::PROC_W-1:0];
    assign w_r          = r_cursor[wfg_pkg::PROC_W +: wfg_pkg::RES_W];
    assign w_cursor_inc = r_cursor + wfg_pkg::CUR_W'(1);
    assign w_wr_addr    = wfg_pkg::PROC_W'(r_depth - wfg_pkg::DEPTH_W'(1));
    assign w_rd_addr    = wfg_pkg::PROC_W'(r_depth - wfg_pkg::DEPTH_W'(2));

    always_comb begin
        o_status.start_end    = (r_start == wfg_pkg::DEPTH_W'(wfg_pkg::NUM_PROCS));
        o_status.start_ok     = r_proc_present[w_start_idx] && !r_visited[w_start_idx];
        o_status.frame_end    = r_cursor[wfg_pkg::CUR_W-1];
        o_status.edge_hit     = r_req[r_cur_proc][w_r] && r_hold[w_h][w_r];
        o_status.hit_on_stack = r_on_stack[w_h];
        o_status.hit_visited  = r_visited[w_h];
        o_status.depth_one    = (r_depth == wfg_pkg::DEPTH_W'(1));
    end

    always_comb begin
        case (i_cmd)
            wfg_pkg::CMD_REM_PROC: w_applied = r_proc_present[i_proc_index];
            wfg_pkg::CMD_REM_RES:  w_applied = r_res_present[i_res_index];
            default:               w_applied = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_present <= '0;
            r_res_present  <= '0;
            for (int i = 0; i < wfg_pkg::NUM_PROCS; i++) begin
                r_req[i]  <= '0;
                r_hold[i] <= '0;
            end
            r_visited   <= '0;
            r_on_stack  <= '0;
            r_depth     <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cmd_ctl.upd) begin
                r_out_valid <= 1'b1;
                case (i_cmd)
                    wfg_pkg::CMD_ADD_PROC: r_proc_present[i_proc_index] <= 1'b1;
                    wfg_pkg::CMD_ADD_RES:  r_res_present[i_res_index] <= 1'b1;
                    wfg_pkg::CMD_REQUEST:  r_req[i_proc_index][i_res_index] <= 1'b1;
                    wfg_pkg::CMD_ALLOCATE: begin
                        r_hold[i_proc_index][i_res_index] <= 1'b1;
                        r_req[i_proc_index][i_res_index]  <= 1'b0;
                    end
                    wfg_pkg::CMD_REM_PROC: begin
                        if (w_applied) begin
                            r_proc_present[i_proc_index] <= 1'b0;
                            r_req[i_proc_index]          <= '0;
                            r_hold[i_proc_index]         <= '0;
                        end
                    end
                    wfg_pkg::CMD_REM_RES: begin
                        if (w_applied) begin
                            r_res_present[i_res_index] <= 1'b0;
                            for (int i = 0; i < wfg_pkg::NUM_PROCS; i++) begin
                                r_req[i][i_res_index]  <= 1'b0;
                                r_hold[i][i_res_index] <= 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd_ctl.det_init) begin
                r_visited  <= '0;
                r_on_stack <= '0;
                r_start    <= '0;
            end
            if (i_cmd_ctl.sel_take) begin
                r_visited[w_start_idx]  <= 1'b1;
                r_on_stack[w_start_idx] <= 1'b1;
                r_depth                 <= wfg_pkg::DEPTH_W'(1);
                r_start                 <= r_start + wfg_pkg::DEPTH_W'(1);
            end
            if (i_cmd_ctl.sel_skip) begin
                r_start <= r_start + wfg_pkg::DEPTH_W'(1);
            end
            if (i_cmd_ctl.push) begin
                r_visited[w_h]  <= 1'b1;
                r_on_stack[w_h] <= 1'b1;
                r_depth         <= r_depth + wfg_pkg::DEPTH_W'(1);
            end
            if (i_cmd_ctl.pop) begin
                r_on_stack[r_cur_proc] <= 1'b0;
                r_depth                <= r_depth - wfg_pkg::DEPTH_W'(1);
            end
            if (i_cmd_ctl.finish_found || i_cmd_ctl.finish_none) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.upd) begin
            r_applied <= w_applied;
            r_found   <= 1'b0;
            r_mask    <= '0;
        end
        if (i_cmd_ctl.finish_found) begin
            r_applied <= 1'b1;
            r_found   <= 1'b1;
            r_mask    <= wfg_pkg::MASK_W'(r_on_stack);
        end
        if (i_cmd_ctl.finish_none) begin
            r_applied <= 1'b1;
            r_found   <= 1'b0;
            r_mask    <= '0;
        end
        if (i_cmd_ctl.sel_take) begin
            r_cur_proc <= w_start_idx;
            r_cursor   <= '0;
        end
        if (i_cmd_ctl.scan_adv) begin
            r_cursor <= w_cursor_inc;
        end
        if (i_cmd_ctl.push) begin
            r_cur_proc <= w_h;
            r_cursor   <= '0;
        end
        if (i_cmd_ctl.load_parent) begin
            {r_cur_proc, r_cursor} <= r_rd_frame;
        end
    end

    // frame stack: parent frames only, current frame lives in r_cur_proc/r_cursor
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.push) begin
            r_frames[w_wr_addr] <= {r_cur_proc, w_cursor_inc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.pop) begin
            r_rd_frame <= r_frames[w_rd_addr];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_applied        = r_applied;
    assign o_deadlock_found = r_found;
    assign o_cycle_mask     = r_mask;

    `ASSERT_CLK(a_stack_in_visited, i_clk, i_rst_n, (r_on_stack & ~r_visited) == '0)
    `ASSERT_CLK(a_depth_bound, i_clk, i_rst_n, r_depth <= wfg_pkg::DEPTH_W'(wfg_pkg::NUM_PROCS))
    `ASSERT_IMPL(a_found_mask, i_clk, i_rst_n, r_out_valid && r_found, r_mask != '0)
    `ASSERT_IMPL(a_push_fresh, i_clk, i_rst_n, i_cmd_ctl.push, !r_visited[w_h])

endmodule

// ----- rtl/wait_for_graph_deadlock_detector.sv -----
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector
// Resource allocation graph keeper with depth-first wait cycle detection.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Add, request,
// allocate and remove commands complete without leaving idle: the result word appears
// with o_valid on the next cycle and busy never rises, so these may be issued
// back to back. Detect raises busy and walks the wait-for graph one edge
// candidate (resource, holder) per cycle while in the scan state; each start
// index passes through a select step, each frame scans up to NUM_RES*NUM_PROCS
// candidates, and each return to a parent frame passes through a load step
// for the frame stack read. The result word is driven for exactly one cycle
// with o_valid high; the receiver cannot stall it and must capture it on that
// cycle.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_cmd,
    input  logic [3:0]                  i_proc_index,
    input  logic [3:0]                  i_res_index,
    output logic                        o_valid,
    output logic                        o_applied,
    output logic                        o_deadlock_found,
    output logic [15:0]                 o_cycle_mask
);

    wfg_pkg::t_dp_cmd    w_cmd_ctl;
    wfg_pkg::t_dp_status w_status;
    logic                w_busy;

    wfg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_status (w_status),
        .o_cmd    (w_cmd_ctl),
        .o_busy   (w_busy)
    );

    wfg_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_ctl        (w_cmd_ctl),
        .i_cmd            (i_cmd),
        .i_proc_index     (i_proc_index),
        .i_res_index      (i_res_index),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_applied        (o_applied),
        .o_deadlock_found (o_deadlock_found),
        .o_cycle_mask     (o_cycle_mask)
    );

    assign busy = w_busy;

endmodule
